// ===== hdl/tsf_pkg.sv =====
// shared constants, types and event formats of the touch sample filter
package tsf_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int SAMPLE_MAX = 4095;
  localparam int POS_W      = 16;
  localparam int GAIN_FRAC  = 14;
  localparam int JITTER_W   = 12;
  localparam int CFG_IDX_W  = 3;

  localparam int SAMPLES_PER_GROUP = 5;
  localparam int TRIM_EACH_END     = 1;
  // trim limited so at least one value survives
  localparam int TRIM = (2 * TRIM_EACH_END >= SAMPLES_PER_GROUP) ?
                        (SAMPLES_PER_GROUP - 1) / 2 : TRIM_EACH_END;
  localparam int KEPT  = SAMPLES_PER_GROUP - 2 * TRIM;
  localparam int IDX_W = $clog2(SAMPLES_PER_GROUP);
  localparam int SUM_W = $clog2(KEPT * SAMPLE_MAX + 1);

  // exact floor division by KEPT as multiply by rounded-up reciprocal
  localparam int DIV_L   = $clog2(KEPT);
  localparam int DIV_SH  = SUM_W + DIV_L;
  localparam int DIV_M   = ((1 << DIV_SH) + KEPT - 1) / KEPT;
  localparam int DIV_M_W = DIV_SH + 1;

  localparam int PROD_W = POS_W + SAMPLE_W + 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    GRP_X1,
    GRP_Y1,
    GRP_X2,
    GRP_Y2
  } grp_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAW_MODE,
    REG_SWAP_AXES,
    REG_X_GAIN,
    REG_Y_GAIN,
    REG_X_OFFSET,
    REG_Y_OFFSET,
    REG_JITTER_LIMIT
  } cfg_reg_e;

  typedef struct packed {
    logic             pen_up;
    grp_e             grp;
    logic [SUM_W-1:0] sum;
  } evt_t;

  typedef struct packed {
    logic                    raw_mode;
    logic                    swap_axes;
    logic signed [POS_W-1:0] x_gain;
    logic signed [POS_W-1:0] y_gain;
    logic signed [POS_W-1:0] x_offset;
    logic signed [POS_W-1:0] y_offset;
    logic [JITTER_W-1:0]     jitter_limit;
  } cfg_t;

endpackage

// ===== hdl/touch_sample_filter_unit.sv =====
// top level of the touch sample filter: stream ports, configuration registers, front and back
//
// Takes one item per cycle on the slave stream: a converter sample (tuser 1) or a pen-up tick
// (tuser 0). Each sample is inserted into a sorted group in the cycle it arrives; the group sum
// of the kept middle values, or a pen-up event, enters a four-entry queue. The back end then
// handles one event per cycle through four register stages (average, jitter check and flags,
// gain multiply, rounding with offset); m_axis_tvalid rises once the item ending a scan or
// a pen-up tick has passed through the queue and these stages, and results sustain one per
// cycle while the master side takes them. The back end halts as a whole while a result waits;
// the queue then fills and tready drops when it is full. Configuration is written through
// cfg_we_i/cfg_idx_i/cfg_data_i and should change only while no item is in flight.
module touch_sample_filter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] sample
  input  logic        s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [15:0] pos_x, [31:16] pos_y, [32] pressed,
                                      // [33] caught, [34] accepted
  input  logic        cfg_we_i,
  input  logic [tsf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  tsf_pkg::cfg_t cfg_q;
  tsf_pkg::evt_t push_evt, pop_evt;
  logic          accept, push, full, pop, evt_valid;
  logic [tsf_pkg::POS_W-1:0] pos_x, pos_y;
  logic          pressed, caught, accepted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.raw_mode     <= 1'b0;
      cfg_q.swap_axes    <= 1'b0;
      cfg_q.x_gain       <= 16'sd16384;
      cfg_q.y_gain       <= 16'sd16384;
      cfg_q.x_offset     <= '0;
      cfg_q.y_offset     <= '0;
      cfg_q.jitter_limit <= 12'd200;
    end else if (cfg_we_i) begin
      case (tsf_pkg::cfg_reg_e'(cfg_idx_i))
        tsf_pkg::REG_RAW_MODE:     cfg_q.raw_mode     <= cfg_data_i[0];
        tsf_pkg::REG_SWAP_AXES:    cfg_q.swap_axes    <= cfg_data_i[0];
        tsf_pkg::REG_X_GAIN:       cfg_q.x_gain       <= cfg_data_i;
        tsf_pkg::REG_Y_GAIN:       cfg_q.y_gain       <= cfg_data_i;
        tsf_pkg::REG_X_OFFSET:     cfg_q.x_offset     <= cfg_data_i;
        tsf_pkg::REG_Y_OFFSET:     cfg_q.y_offset     <= cfg_data_i;
        tsf_pkg::REG_JITTER_LIMIT: cfg_q.jitter_limit <= cfg_data_i[tsf_pkg::JITTER_W-1:0];
        default:                   cfg_q              <= cfg_q;
      endcase
    end
  end

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  tsf_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .kind_i   (s_axis_tuser),
    .sample_i (s_axis_tdata[tsf_pkg::SAMPLE_W-1:0]),
    .push_o   (push),
    .evt_o    (push_evt)
  );

  tsf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_evt),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (evt_valid),
    .rdata_o (pop_evt)
  );

  tsf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .evt_valid_i (evt_valid),
    .evt_i       (pop_evt),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .pos_x_o     (pos_x),
    .pos_y_o     (pos_y),
    .pressed_o   (pressed),
    .caught_o    (caught),
    .accepted_o  (accepted)
  );

  assign m_axis_tdata = {5'b0, accepted, caught, pressed, pos_y, pos_x};

endmodule

// ===== hdl/tsf_front.sv =====
// front end: sorted insertion of samples and group sum of the kept middle values
module tsf_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic                             kind_i,
  input  logic [tsf_pkg::SAMPLE_W-1:0]     sample_i,
  output logic                             push_o,
  output tsf_pkg::evt_t                    evt_o
);

  logic [tsf_pkg::SAMPLE_W-1:0] srt_q [tsf_pkg::SAMPLES_PER_GROUP];
  logic [tsf_pkg::SAMPLE_W-1:0] ins   [tsf_pkg::SAMPLES_PER_GROUP];
  logic [tsf_pkg::SAMPLES_PER_GROUP-1:0] lt;
  logic [tsf_pkg::IDX_W-1:0] idx_q, idx_d;
  tsf_pkg::grp_e             grp_q, grp_d;
  logic [tsf_pkg::SUM_W-1:0] sum;
  logic                      group_end;

  assign group_end = (idx_q == tsf_pkg::IDX_W'(tsf_pkg::SAMPLES_PER_GROUP - 1));

  always_comb begin
    for (int i = 0; i < tsf_pkg::SAMPLES_PER_GROUP; i++) begin
      lt[i] = (tsf_pkg::IDX_W'(i) < idx_q) && (srt_q[i] <= sample_i);
    end
    // entries below the insertion point stay, the rest move up one place
    ins[0] = lt[0] ? srt_q[0] : sample_i;
    for (int i = 1; i < tsf_pkg::SAMPLES_PER_GROUP; i++) begin
      ins[i] = lt[i] ? srt_q[i] : (lt[i-1] ? sample_i : srt_q[i-1]);
    end
    sum = '0;
    for (int i = tsf_pkg::TRIM; i < tsf_pkg::SAMPLES_PER_GROUP - tsf_pkg::TRIM; i++) begin
      sum = sum + tsf_pkg::SUM_W'(ins[i]);
    end
  end

  always_comb begin
    idx_d = idx_q;
    grp_d = grp_q;
    if (accept_i) begin
      if (!kind_i) begin
        idx_d = '0;
        grp_d = tsf_pkg::GRP_X1;
      end else if (group_end) begin
        idx_d = '0;
        grp_d = tsf_pkg::grp_e'(grp_q + 2'd1);
      end else begin
        idx_d = idx_q + tsf_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      grp_q <= tsf_pkg::GRP_X1;
    end else begin
      idx_q <= idx_d;
      grp_q <= grp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && kind_i) begin
      for (int i = 0; i < tsf_pkg::SAMPLES_PER_GROUP; i++) begin
        srt_q[i] <= ins[i];
      end
    end
  end

  assign push_o     = accept_i && (!kind_i || group_end);
  assign evt_o.pen_up = !kind_i;
  assign evt_o.grp    = grp_q;
  assign evt_o.sum    = sum;

endmodule

// ===== hdl/tsf_queue.sv =====
// short event queue between front end and back end
module tsf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tsf_pkg::evt_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output tsf_pkg::evt_t rdata_o
);

  tsf_pkg::evt_t mem_q [tsf_pkg::QUEUE_DEPTH];
  logic [tsf_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [tsf_pkg::QPTR_W:0]   cnt_q;
  logic                       do_push, do_pop;

  assign full_o  = (cnt_q == (tsf_pkg::QPTR_W+1)'(tsf_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + tsf_pkg::QPTR_W'(1);
      if (do_pop)  rd_q <= rd_q + tsf_pkg::QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + (tsf_pkg::QPTR_W+1)'(1);
        2'b01:   cnt_q <= cnt_q - (tsf_pkg::QPTR_W+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= wdata_i;
  end

endmodule

// ===== hdl/tsf_back.sv =====
// back end: group average, jitter check, flags, calibration and result register
module tsf_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tsf_pkg::cfg_t                cfg_i,
  input  logic                         evt_valid_i,
  input  tsf_pkg::evt_t                evt_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tsf_pkg::POS_W-1:0]    pos_x_o,
  output logic [tsf_pkg::POS_W-1:0]    pos_y_o,
  output logic                         pressed_o,
  output logic                         caught_o,
  output logic                         accepted_o
);

  localparam int SW = tsf_pkg::SAMPLE_W;
  localparam int PW = tsf_pkg::POS_W;

  logic adv;

  // stage a: average
  logic                        a_valid_q;
  logic                        a_pen_up_q;
  tsf_pkg::grp_e               a_grp_q;
  logic [SW-1:0]               a_avg_q;
  logic [tsf_pkg::SUM_W+tsf_pkg::DIV_M_W-1:0] quot_full;

  // stage b: pair store, jitter check, flags
  logic [SW-1:0] x1_q, y1_q, x2_q;
  logic          pressed_q, pressed_d, caught_q, caught_d;
  logic          b_valid_q, b_valid_d, b_acc_q, b_acc_d;
  logic          b_pressed_q, b_caught_q;
  logic [SW-1:0] b_ra_q, b_ra_d, b_rb_q, b_rb_d;
  logic [SW-1:0] dx, dy, rx, ry;
  logic [SW:0]   sx, sy;
  logic          jit_bad;

  // stage c: products
  logic                                c_valid_q, c_acc_q, c_pressed_q, c_caught_q;
  logic [SW-1:0]                       c_ra_q, c_rb_q;
  logic signed [tsf_pkg::PROD_W-1:0]   c_px_q, c_py_q;

  // output stage
  logic [PW-1:0] held_x_q, held_y_q, new_x, new_y;
  logic [PW-1:0] out_x_q, out_y_q;
  logic          out_valid_q, out_pressed_q, out_caught_q, out_acc_q;
  logic signed [PW-1:0] qx, qy;
  logic          corr_x, corr_y;

  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv && evt_valid_i;

  assign quot_full = evt_i.sum * tsf_pkg::DIV_M_W'(tsf_pkg::DIV_M);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= evt_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_pen_up_q <= evt_i.pen_up;
      a_grp_q    <= evt_i.grp;
      a_avg_q    <= quot_full[tsf_pkg::DIV_SH +: SW];
    end
  end

  assign dx = (x1_q > x2_q) ? x1_q - x2_q : x2_q - x1_q;
  assign dy = (y1_q > a_avg_q) ? y1_q - a_avg_q : a_avg_q - y1_q;
  assign jit_bad = (dx > cfg_i.jitter_limit) || (dy > cfg_i.jitter_limit);
  assign sx = {1'b0, x1_q} + {1'b0, x2_q};
  assign sy = {1'b0, y1_q} + {1'b0, a_avg_q};
  assign rx = sx[SW:1];
  assign ry = sy[SW:1];

  always_comb begin
    pressed_d = pressed_q;
    caught_d  = caught_q;
    b_valid_d = 1'b0;
    b_acc_d   = 1'b0;
    b_ra_d    = rx;
    b_rb_d    = ry;
    if (!cfg_i.raw_mode && cfg_i.swap_axes) begin
      b_ra_d = ry;
      b_rb_d = rx;
    end
    if (a_valid_q) begin
      if (a_pen_up_q) begin
        // a press survives one pen-up tick as caught
        if (!pressed_q) caught_d = 1'b0;
        pressed_d = 1'b0;
        b_valid_d = 1'b1;
      end else if (a_grp_q == tsf_pkg::GRP_Y2) begin
        b_valid_d = 1'b1;
        if (jit_bad) begin
          pressed_d = 1'b0;
          caught_d  = 1'b0;
        end else begin
          pressed_d = 1'b1;
          caught_d  = 1'b1;
          b_acc_d   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q      <= '0;
      y1_q      <= '0;
      x2_q      <= '0;
      pressed_q <= 1'b0;
      caught_q  <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (adv) begin
      pressed_q <= pressed_d;
      caught_q  <= caught_d;
      b_valid_q <= b_valid_d;
      if (a_valid_q && !a_pen_up_q) begin
        case (a_grp_q)
          tsf_pkg::GRP_X1: x1_q <= a_avg_q;
          tsf_pkg::GRP_Y1: y1_q <= a_avg_q;
          tsf_pkg::GRP_X2: x2_q <= a_avg_q;
          default:         x1_q <= x1_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_acc_q     <= b_acc_d;
      b_pressed_q <= pressed_d;
      b_caught_q  <= caught_d;
      b_ra_q      <= b_ra_d;
      b_rb_q      <= b_rb_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (adv) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_acc_q     <= b_acc_q;
      c_pressed_q <= b_pressed_q;
      c_caught_q  <= b_caught_q;
      c_ra_q      <= b_ra_q;
      c_rb_q      <= b_rb_q;
      c_px_q      <= cfg_i.x_gain * $signed({1'b0, b_ra_q});
      c_py_q      <= cfg_i.y_gain * $signed({1'b0, b_rb_q});
    end
  end

  // floor shift plus one for negative products with a fraction: truncation toward zero
  assign qx     = PW'(c_px_q >>> tsf_pkg::GAIN_FRAC);
  assign qy     = PW'(c_py_q >>> tsf_pkg::GAIN_FRAC);
  assign corr_x = c_px_q[tsf_pkg::PROD_W-1] && (|c_px_q[tsf_pkg::GAIN_FRAC-1:0]);
  assign corr_y = c_py_q[tsf_pkg::PROD_W-1] && (|c_py_q[tsf_pkg::GAIN_FRAC-1:0]);

  always_comb begin
    if (cfg_i.raw_mode) begin
      new_x = PW'(c_ra_q);
      new_y = PW'(c_rb_q);
    end else begin
      new_x = qx + PW'(corr_x) + cfg_i.x_offset;
      new_y = qy + PW'(corr_y) + cfg_i.y_offset;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_x_q    <= '0;
      held_y_q    <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= c_valid_q;
      if (c_valid_q && c_acc_q) begin
        held_x_q <= new_x;
        held_y_q <= new_y;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_x_q       <= c_acc_q ? new_x : held_x_q;
      out_y_q       <= c_acc_q ? new_y : held_y_q;
      out_pressed_q <= c_pressed_q;
      out_caught_q  <= c_caught_q;
      out_acc_q     <= c_acc_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_x_q;
  assign pos_y_o     = out_y_q;
  assign pressed_o   = out_pressed_q;
  assign caught_o    = out_caught_q;
  assign accepted_o  = out_acc_q;

endmodule
